### design/pcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// shared types and constants for the premultiplied color matrix core
// ----------------------------------------------------------------------------
package pcm_pkg;

	localparam int ROW_BITS  = 60;
	localparam int SLOT_BITS = 12;
	localparam int CHAN_BITS = 8;
	localparam int NUM_ROWS  = 4;
	localparam int IDX_BITS  = 2;

	// register indexes
	localparam logic [IDX_BITS-1:0] REG_ROW_RED   = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_ROW_GREEN = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_ROW_BLUE  = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_ROW_ALPHA = 2'd3;

	// identity matrix rows
	localparam logic [ROW_BITS-1:0] ROW_RED_RST   = 60'd255;
	localparam logic [ROW_BITS-1:0] ROW_GREEN_RST = 60'd255 << 12;
	localparam logic [ROW_BITS-1:0] ROW_BLUE_RST  = 60'd255 << 24;
	localparam logic [ROW_BITS-1:0] ROW_ALPHA_RST = 60'd255 << 36;

	// exact divide by 255 for products below 2**16
	localparam int             D255_SHIFT = 24;
	localparam logic [16:0]    D255_RCP   = 17'd65794;

	typedef struct packed {
		logic [CHAN_BITS-1:0] in_red;
		logic [CHAN_BITS-1:0] in_green;
		logic [CHAN_BITS-1:0] in_blue;
		logic [CHAN_BITS-1:0] in_alpha;
	} in_pixel_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] out_red;
		logic [CHAN_BITS-1:0] out_green;
		logic [CHAN_BITS-1:0] out_blue;
		logic [CHAN_BITS-1:0] out_alpha;
	} out_pixel_t;

endpackage

### design/premultiplied_color_matrix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// premultiplied_color_matrix_core
// 4x5 color matrix on premultiplied rgba words, five register stages
// ----------------------------------------------------------------------------
// throughput: one word per cycle while out_ready is high; each stage stalls only when it and every
//   stage after it hold words, so bubbles are squeezed out under back-pressure
// divides by the input alpha use a 256-entry reciprocal table and one
//   multiply, exact for every product magnitude; divides by 255 likewise
// reset: pipeline empty, matrix rows return to the identity matrix
module premultiplied_color_matrix_core #(
	parameter int COEF_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pcm_pkg::IDX_BITS-1:0]     cfg_index,
	input  logic [pcm_pkg::ROW_BITS-1:0]     cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pcm_pkg::in_pixel_t               in_pixel,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pcm_pkg::out_pixel_t              out_pixel
);

	// magnitude of coef*channel stays below 2**(COEF_BITS+7)
	localparam int MAG_W  = COEF_BITS + 7;
	localparam int PROD_W = COEF_BITS + 9;
	localparam int K      = MAG_W + 8;
	localparam int RCP_W  = K + 1;
	localparam int SUM_W  = MAG_W + 4;
	localparam int CW     = pcm_pkg::CHAN_BITS;

	// ---------------- configuration rows
	logic [pcm_pkg::ROW_BITS-1:0] row_q [pcm_pkg::NUM_ROWS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= pcm_pkg::ROW_RED_RST;
			row_q[1] <= pcm_pkg::ROW_GREEN_RST;
			row_q[2] <= pcm_pkg::ROW_BLUE_RST;
			row_q[3] <= pcm_pkg::ROW_ALPHA_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcm_pkg::REG_ROW_RED:   row_q[0] <= cfg_data;
				pcm_pkg::REG_ROW_GREEN: row_q[1] <= cfg_data;
				pcm_pkg::REG_ROW_BLUE:  row_q[2] <= cfg_data;
				pcm_pkg::REG_ROW_ALPHA: row_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficient of a row slot, sign extended from COEF_BITS
	logic signed [COEF_BITS-1:0] coef [pcm_pkg::NUM_ROWS][5];
	always_comb begin
		for (int r = 0; r < pcm_pkg::NUM_ROWS; r++)
			for (int s = 0; s < 5; s++)
				coef[r][s] = $signed(row_q[r][s*pcm_pkg::SLOT_BITS +: COEF_BITS]);
	end

	// ---------------- reciprocal table, ceil(2**K / d)
	logic [RCP_W-1:0] rcp_tab [256];
	for (genvar gi = 0; gi < 256; gi++) begin : g_rcp
		localparam longint unsigned D = (gi == 0) ? 1 : gi;
		localparam longint unsigned R = ((64'd1 << K) + D - 1) / D;
		assign rcp_tab[gi] = RCP_W'(R);
	end

	// ---------------- handshake chain
	logic v1, v2, v3, v4, v5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	assign rdy5     = !v5 || out_ready;
	assign rdy4     = !v4 || rdy5;
	assign rdy3     = !v3 || rdy4;
	assign rdy2     = !v2 || rdy3;
	assign rdy1     = !v1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = v5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
		end else begin
			if (rdy1) v1 <= in_valid;
			if (rdy2) v2 <= v1;
			if (rdy3) v3 <= v2;
			if (rdy4) v4 <= v3;
			if (rdy5) v5 <= v4;
		end
	end

	// ---------------- stage 1: coef * channel, split into sign and magnitude
	// term 0..2 are color terms over alpha, term 3 is the alpha term over 255
	logic [MAG_W-1:0]            mag_s1 [pcm_pkg::NUM_ROWS][4];
	logic                        neg_s1 [pcm_pkg::NUM_ROWS][4];
	logic signed [COEF_BITS-1:0] off_s1 [pcm_pkg::NUM_ROWS];
	logic [RCP_W-1:0]            rcp_s1;
	logic                        azero_s1;

	logic [CW-1:0]           chan [4];
	logic signed [PROD_W-1:0] prod [pcm_pkg::NUM_ROWS][4];
	logic [PROD_W-1:0]        pabs [pcm_pkg::NUM_ROWS][4];
	always_comb begin
		chan[0] = in_pixel.in_red;
		chan[1] = in_pixel.in_green;
		chan[2] = in_pixel.in_blue;
		chan[3] = in_pixel.in_alpha;
		for (int r = 0; r < pcm_pkg::NUM_ROWS; r++)
			for (int t = 0; t < 4; t++) begin
				prod[r][t] = PROD_W'(coef[r][t] * $signed({1'b0, chan[t]}));
				pabs[r][t] = prod[r][t][PROD_W-1] ? PROD_W'(-prod[r][t])
					: PROD_W'(prod[r][t]);
			end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int r = 0; r < pcm_pkg::NUM_ROWS; r++) begin
				for (int t = 0; t < 4; t++) begin
					mag_s1[r][t] <= pabs[r][t][MAG_W-1:0];
					neg_s1[r][t] <= prod[r][t][PROD_W-1];
				end
				off_s1[r] <= coef[r][4];
			end
			rcp_s1   <= rcp_tab[in_pixel.in_alpha];
			azero_s1 <= (in_pixel.in_alpha == '0);
		end
	end

	// ---------------- stage 2: truncating divide by reciprocal multiply
	logic signed [MAG_W:0]       quo_s2 [pcm_pkg::NUM_ROWS][4];
	logic signed [COEF_BITS-1:0] off_s2 [pcm_pkg::NUM_ROWS];
	logic                        azero_s2;

	logic [MAG_W+RCP_W-1:0] qprod [pcm_pkg::NUM_ROWS][4];
	logic [MAG_W-1:0]       qmag  [pcm_pkg::NUM_ROWS][4];
	always_comb begin
		for (int r = 0; r < pcm_pkg::NUM_ROWS; r++)
			for (int t = 0; t < 4; t++) begin
				qprod[r][t] = (MAG_W+RCP_W)'(mag_s1[r][t])
					* (MAG_W+RCP_W)'((t == 3) ? rcp_tab[255] : rcp_s1);
				qmag[r][t] = qprod[r][t][K +: MAG_W];
			end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v1) begin
			for (int r = 0; r < pcm_pkg::NUM_ROWS; r++) begin
				for (int t = 0; t < 4; t++)
					quo_s2[r][t] <= neg_s1[r][t] ? -$signed({1'b0, qmag[r][t]})
						: $signed({1'b0, qmag[r][t]});
				off_s2[r] <= off_s1[r];
			end
			azero_s2 <= azero_s1;
		end
	end

	// ---------------- stage 3: add terms and offset (offset alone for a transparent source), clamp to a byte
	logic [CW-1:0] ch_s3 [pcm_pkg::NUM_ROWS];

	logic signed [SUM_W-1:0] sum [pcm_pkg::NUM_ROWS];
	logic [CW-1:0]           clp [pcm_pkg::NUM_ROWS];
	always_comb begin
		for (int r = 0; r < pcm_pkg::NUM_ROWS; r++) begin
			// transparent source: offset alone
			if (azero_s2)
				sum[r] = SUM_W'(off_s2[r]);
			else
				sum[r] = SUM_W'(quo_s2[r][0]) + SUM_W'(quo_s2[r][1])
					+ SUM_W'(quo_s2[r][2]) + SUM_W'(quo_s2[r][3])
					+ SUM_W'(off_s2[r]);
			if (sum[r] < 0)
				clp[r] = '0;
			else if (sum[r] > SUM_W'(255))
				clp[r] = '1;
			else
				clp[r] = sum[r][CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v2)
			for (int r = 0; r < pcm_pkg::NUM_ROWS; r++)
				ch_s3[r] <= clp[r];
	end

	// ---------------- stage 4: color times output alpha
	logic [2*CW-1:0] pm_s4 [3];
	logic [CW-1:0]   a_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v3) begin
			for (int c = 0; c < 3; c++)
				pm_s4[c] <= (2*CW)'(ch_s3[c]) * (2*CW)'(ch_s3[3]);
			a_s4 <= ch_s3[3];
		end
	end

	// ---------------- stage 5: divide by 255, output register
	logic [2*CW+17-1:0] dprod [3];
	always_comb begin
		for (int c = 0; c < 3; c++)
			dprod[c] = (2*CW+17)'(pm_s4[c]) * (2*CW+17)'(pcm_pkg::D255_RCP);
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v4) begin
			out_pixel.out_red   <= dprod[0][pcm_pkg::D255_SHIFT +: CW];
			out_pixel.out_green <= dprod[1][pcm_pkg::D255_SHIFT +: CW];
			out_pixel.out_blue  <= dprod[2][pcm_pkg::D255_SHIFT +: CW];
			out_pixel.out_alpha <= a_s4;
		end
	end

	// ---------------- checks
	// premultiplied result never has color above alpha
	a_red_le_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_pixel.out_red <= out_pixel.out_alpha)
		else $error("red above alpha");
	a_gb_le_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_pixel.out_green <= out_pixel.out_alpha)
			&& (out_pixel.out_blue <= out_pixel.out_alpha))
		else $error("green or blue above alpha");
	// input stalls only with every stage full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v1 && v2 && v3 && v4 && v5 && !out_ready)
		else $error("stall with a bubble in the pipeline");

endmodule

### sim/premultiplied_color_matrix_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// premultiplied_color_matrix_core_tb
// drives pixel words through the color matrix core under several matrix
// settings and idle patterns, predicts each output word and checks it in order
// ----------------------------------------------------------------------------

class pixel_scoreboard;
	pcm_pkg::out_pixel_t pending[$];
	logic [59:0] rows [4];
	int coef_bits;
	int mismatches;
	int checked;

	function new(int cb);
		coef_bits = cb;
		mismatches = 0;
		checked = 0;
		rows[0] = pcm_pkg::ROW_RED_RST;
		rows[1] = pcm_pkg::ROW_GREEN_RST;
		rows[2] = pcm_pkg::ROW_BLUE_RST;
		rows[3] = pcm_pkg::ROW_ALPHA_RST;
	endfunction

	function int coef(int row, int slot);
		logic [11:0] raw;
		int v;
		raw = rows[row][slot*12 +: 12];
		v = int'(raw & ((12'd1 << coef_bits) - 1));
		if (raw[coef_bits-1])
			v -= (1 << coef_bits);
		return v;
	endfunction

	function int clamp8(int v);
		if (v < 0)
			return 0;
		if (v > 255)
			return 255;
		return v;
	endfunction

	// one output channel before the premultiply
	function int channel_sum(int row, int px[4]);
		int s;
		if (px[3] == 0)
			return clamp8(coef(row, 4));
		s = 0;
		for (int k = 0; k < 3; k++)
			s += coef(row, k) * px[k] / px[3];
		s += coef(row, 3) * px[3] / 255;
		s += coef(row, 4);
		return clamp8(s);
	endfunction

	function void note_pixel(pcm_pkg::in_pixel_t p);
		int px[4];
		int c[4];
		pcm_pkg::out_pixel_t e;
		px[0] = p.in_red;
		px[1] = p.in_green;
		px[2] = p.in_blue;
		px[3] = p.in_alpha;
		for (int r = 0; r < 4; r++)
			c[r] = channel_sum(r, px);
		e.out_red = 8'(c[0] * c[3] / 255);
		e.out_green = 8'(c[1] * c[3] / 255);
		e.out_blue = 8'(c[2] * c[3] / 255);
		e.out_alpha = 8'(c[3]);
		pending.push_back(e);
	endfunction

	function void check_pixel(pcm_pkg::out_pixel_t got);
		pcm_pkg::out_pixel_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected output word %h", got);
			return;
		end
		e = pending.pop_front();
		checked++;
		if (got !== e) begin
			mismatches++;
			if (mismatches <= 10)
				$display("word %0d mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
					checked, e.out_red, e.out_green, e.out_blue, e.out_alpha,
					got.out_red, got.out_green, got.out_blue, got.out_alpha);
		end
	endfunction
endclass

module premultiplied_color_matrix_core_tb;

	localparam int COEF_W = 12;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pcm_pkg::IDX_BITS-1:0] cfg_index;
	logic [pcm_pkg::ROW_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	pcm_pkg::in_pixel_t in_pixel;
	logic out_valid;
	logic out_ready;
	pcm_pkg::out_pixel_t out_pixel;

	// idle percentages for the sender and the receiver, set per phase
	int send_idle;
	int recv_stall;
	// long receiver hold-off, counted down in the receiver process
	int hold_cycles;
	int cycles;

	pixel_scoreboard sb;

	premultiplied_color_matrix_core #(.COEF_BITS(COEF_W)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
		.out_valid(out_valid), .out_ready(out_ready), .out_pixel(out_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// input word is noted for prediction when accepted
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_pixel(in_pixel);
		if (arst_n && out_valid && out_ready)
			sb.check_pixel(out_pixel);
	end

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("premultiplied_color_matrix_core_tb NOT OK");
			$finish;
		end
	end

	// register write while the core is idle
	task automatic write_row(logic [pcm_pkg::IDX_BITS-1:0] idx,
		logic [pcm_pkg::ROW_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.rows[idx] = val;
	endtask

	// offer one word, holding it until accepted; random gaps before it
	task automatic send_pixel(pcm_pkg::in_pixel_t p);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_pixel <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [11:0] rand_coef();
		case ($urandom_range(5))
			0: return 12'h7FF;
			1: return 12'h800;
			2: return 12'(255);
			3: return 12'($urandom_range(600)) - 12'd300;
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic logic [pcm_pkg::ROW_BITS-1:0] rand_row();
		logic [pcm_pkg::ROW_BITS-1:0] r;
		for (int s = 0; s < 5; s++)
			r[s*12 +: 12] = rand_coef();
		return r;
	endfunction

	// mostly valid premultiplied pixels, some with color above alpha
	function automatic pcm_pkg::in_pixel_t rand_pixel();
		pcm_pkg::in_pixel_t p;
		p.in_alpha = 8'($urandom_range(255));
		if ($urandom_range(9) == 0)
			p.in_alpha = 8'd0;
		if ($urandom_range(4) == 0) begin
			p.in_red = 8'($urandom);
			p.in_green = 8'($urandom);
			p.in_blue = 8'($urandom);
		end else begin
			p.in_red = 8'($urandom_range(p.in_alpha));
			p.in_green = 8'($urandom_range(p.in_alpha));
			p.in_blue = 8'($urandom_range(p.in_alpha));
		end
		return p;
	endfunction

	task automatic random_rows();
		for (int i = 0; i < 4; i++)
			write_row(i[pcm_pkg::IDX_BITS-1:0], rand_row());
	endtask

	initial begin
		sb = new(COEF_W);
		cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pcm_pkg::REG_ROW_RED;
		cfg_data = '0;
		in_valid = 1'b0;
		in_pixel = '0;
		out_ready = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		hold_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: identity matrix first, then extremes and transparent words
		send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
		send_pixel('{8'd128, 8'd64, 8'd1, 8'd128});
		send_pixel('{8'd255, 8'd200, 8'd100, 8'd1});
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd0});
		drain();
		// offsets only, transparent input takes the clamped offsets
		write_row(pcm_pkg::REG_ROW_RED, {12'h7FF, 48'd0});
		write_row(pcm_pkg::REG_ROW_GREEN, {12'h800, 48'd0});
		write_row(pcm_pkg::REG_ROW_BLUE, {12'd100, 48'd0});
		write_row(pcm_pkg::REG_ROW_ALPHA, {12'd200, 48'd0});
		send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
		send_pixel('{8'd9, 8'd8, 8'd7, 8'd0});
		send_pixel('{8'd50, 8'd50, 8'd50, 8'd100});
		drain();
		// most positive coefficients everywhere, then most negative terms with the most positive offset
		for (int i = 0; i < 4; i++)
			write_row(i[pcm_pkg::IDX_BITS-1:0], {5{12'h7FF}});
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
		send_pixel('{8'd255, 8'd0, 8'd0, 8'd1});
		send_pixel('{8'd1, 8'd1, 8'd1, 8'd2});
		drain();
		for (int i = 0; i < 4; i++)
			write_row(i[pcm_pkg::IDX_BITS-1:0], {12'h7FF, {4{12'h800}}});
		send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
		send_pixel('{8'd0, 8'd0, 8'd0, 8'd255});
		send_pixel('{8'd3, 8'd2, 8'd1, 8'd7});
		drain();
		// color above alpha, then a valid word, with a mixed matrix
		write_row(pcm_pkg::REG_ROW_RED, {12'd10, 12'd0, 12'h800, 12'd300, 12'd255});
		write_row(pcm_pkg::REG_ROW_GREEN, {12'hF00, 12'd128, 12'd50, 12'd255, 12'd0});
		write_row(pcm_pkg::REG_ROW_BLUE, {12'd0, 12'd0, 12'd255, 12'hFFF, 12'd1});
		write_row(pcm_pkg::REG_ROW_ALPHA, {12'd0, 12'd255, 12'd85, 12'd85, 12'd85});
		send_pixel('{8'd200, 8'd150, 8'd100, 8'd50});
		send_pixel('{8'd255, 8'd255, 8'd0, 8'd3});
		send_pixel('{8'd170, 8'd85, 8'd255, 8'd255});
		drain();

		// random phases: no idling, sender idle, receiver stalling, both
		for (int ph = 0; ph < 8; ph++) begin
			random_rows();
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 85; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 85; end
				default: begin send_idle = 9; recv_stall = 9; end
			endcase
			// long hold-off while the sender keeps offering
			if (ph == 4)
				hold_cycles = 60;
			for (int n = 0; n < 110; n++)
				send_pixel(rand_pixel());
			// sender pauses until all results are back
			drain();
		end
		// back to identity for the last random burst
		write_row(pcm_pkg::REG_ROW_RED, pcm_pkg::ROW_RED_RST);
		write_row(pcm_pkg::REG_ROW_GREEN, pcm_pkg::ROW_GREEN_RST);
		write_row(pcm_pkg::REG_ROW_BLUE, pcm_pkg::ROW_BLUE_RST);
		write_row(pcm_pkg::REG_ROW_ALPHA, pcm_pkg::ROW_ALPHA_RST);
		send_idle = 9;
		recv_stall = 9;
		for (int n = 0; n < 60; n++)
			send_pixel(rand_pixel());
		drain();

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("premultiplied_color_matrix_core_tb OK");
		else
			$display("premultiplied_color_matrix_core_tb NOT OK");
		$finish;
	end
endmodule

### premultiplied_color_matrix_core.f
design/pcm_pkg.sv
design/premultiplied_color_matrix_core.sv
sim/premultiplied_color_matrix_core_tb.sv
